@@ rtl/core/lbem_pkg.sv @@
package lbem_pkg;

    // lux values are unsigned Q(32-F).F
    localparam int unsigned FRACTION_BITS = 16;
    localparam int unsigned LUX_W         = 32;
    localparam int unsigned CFG_W         = 16;
    localparam int unsigned GAIN_SHIFT    = 16;
    localparam int unsigned THRESH_COUNT  = 18;
    localparam int unsigned TIME_COUNT    = 20;
    localparam int unsigned INDEX_W       = 5;
    localparam int unsigned TIME_W        = 11;
    localparam int unsigned CFG_IDX_W     = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DARK_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FACTOR = 1'b1;

    // register reset values (0.4 and 0.9)
    localparam logic [CFG_W-1:0] DARK_OFFSET_RESET = 16'd26214;
    localparam logic [CFG_W-1:0] GAIN_FACTOR_RESET = 16'd58982;

    // index reported for an all-saturated burst
    localparam logic [INDEX_W-1:0] NO_VALID_INDEX = 5'd1;

    // shutter thresholds, lux scaled by 2^24
    localparam logic [31:0] THRESH_Q24 [0:THRESH_COUNT-1] = '{
        32'd2013266,  32'd2097152,  32'd2323644,  32'd2550137,  32'd3103785,
        32'd3690988,  32'd4613734,  32'd5788140,  32'd7851737,  32'd9730785,
        32'd13455327, 32'd18706596, 32'd26843546, 32'd39426458, 32'd57042534,
        32'd70464307, 32'd167772160, 32'd1677721600
    };

    // shutter timer value in ms per index
    localparam logic [TIME_W-1:0] TIME_TABLE [0:TIME_COUNT-1] = '{
        11'd1050, 11'd540, 11'd470, 11'd300, 11'd290, 11'd175, 11'd136,
        11'd97,   11'd79,  11'd60,  11'd52,  11'd45,  11'd41,  11'd37,
        11'd34,   11'd32,  11'd28,  11'd25,  11'd23,  11'd22
    };

    typedef struct packed {
        logic [LUX_W-1:0] lux_sample;
        logic             saturated;
    } lbem_sample_t;

    typedef struct packed {
        logic [LUX_W-1:0]   adjusted_lux;
        logic [INDEX_W-1:0] shutter_index;
        logic [TIME_W-1:0]  shutter_time_ms;
        logic               no_valid_samples;
    } lbem_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SUBTRACT,
        ST_MULTIPLY,
        ST_EMIT
    } lbem_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic subtract;
        logic multiply;
        logic emit;
    } lbem_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic burst_last;
        logic div_last;
        logic no_valid;
    } lbem_stat_t;

    // first threshold the lux value does not exceed, else one past the table
    function automatic logic [INDEX_W-1:0] pick_index(input logic [LUX_W-1:0] lux);
        logic [INDEX_W-1:0] idx;
        idx = INDEX_W'(THRESH_COUNT + 1);
        for (int k = THRESH_COUNT - 1; k >= 0; k--)
        begin
            if (lux <= (THRESH_Q24[k] >> (24 - FRACTION_BITS)))
            begin
                idx = INDEX_W'(k + 1);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/lbem_datapath.sv @@
module lbem_datapath
    import lbem_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lbem_cmd_t            cmd,
    output lbem_stat_t           stat,
    input  lbem_sample_t         sample,
    output lbem_result_t         result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ACC_W  = LUX_W + $clog2(SAMPLES_PER_READING);
    localparam int CNT_W  = $clog2(SAMPLES_PER_READING + 1);
    localparam int STEP_W = $clog2(ACC_W);

    logic [CFG_W-1:0]  dark_offset_reg, dark_offset_next;
    logic [CFG_W-1:0]  gain_factor_reg, gain_factor_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [LUX_W-1:0]  diff_reg, diff_next;
    logic [LUX_W-1:0]  adj_reg, adj_next;
    lbem_result_t      result_reg, result_next;

    logic [CNT_W:0]             rem_shift;
    logic                       rem_ge;
    logic [CNT_W:0]             rem_sub;
    logic [LUX_W-1:0]           quotient;
    logic [LUX_W+CFG_W-1:0]     product;
    logic [INDEX_W-1:0]         index_sel;

    // configuration registers
    always_comb
    begin
        dark_offset_next = dark_offset_reg;
        gain_factor_next = gain_factor_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DARK_OFFSET: dark_offset_next = cfg_data;
                REG_GAIN_FACTOR: gain_factor_next = cfg_data;
                default: ;
            endcase
        end
    end

    // restoring divide step, one quotient bit per cycle shifted into the sum
    assign rem_shift = {rem_reg, acc_reg[ACC_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, count_reg};
    assign rem_sub   = rem_shift - {1'b0, count_reg};
    assign quotient  = acc_reg[LUX_W-1:0];

    assign product   = (LUX_W+CFG_W)'(diff_reg) * (LUX_W+CFG_W)'(gain_factor_reg);
    assign index_sel = pick_index(adj_reg);

    // burst sum, count and divider
    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        if (cmd.accept)
        begin
            rem_next  = '0;
            step_next = '0;
            pos_next  = stat.burst_last ? '0 : pos_reg + CNT_W'(1);
            if (!sample.saturated)
            begin
                acc_next   = acc_reg + ACC_W'(sample.lux_sample);
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (cmd.div_step)
        begin
            rem_next  = rem_ge ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            acc_next  = {acc_reg[ACC_W-2:0], rem_ge};
            step_next = step_reg + STEP_W'(1);
        end
        else if (cmd.emit)
        begin
            acc_next   = '0;
            count_next = '0;
        end
    end

    // offset, gain and result
    always_comb
    begin
        diff_next   = diff_reg;
        adj_next    = adj_reg;
        result_next = result_reg;
        if (cmd.subtract)
        begin
            diff_next = (quotient > LUX_W'(dark_offset_reg))
                      ? quotient - LUX_W'(dark_offset_reg) : '0;
        end
        if (cmd.multiply)
        begin
            adj_next = product[LUX_W+GAIN_SHIFT-1:GAIN_SHIFT];
        end
        if (cmd.emit)
        begin
            if (stat.no_valid)
            begin
                result_next.adjusted_lux     = '0;
                result_next.shutter_index    = NO_VALID_INDEX;
                result_next.shutter_time_ms  = TIME_TABLE[NO_VALID_INDEX];
                result_next.no_valid_samples = 1'b1;
            end
            else
            begin
                result_next.adjusted_lux     = adj_reg;
                result_next.shutter_index    = index_sel;
                result_next.shutter_time_ms  = TIME_TABLE[index_sel];
                result_next.no_valid_samples = 1'b0;
            end
        end
    end

    assign stat.burst_last = pos_reg == CNT_W'(SAMPLES_PER_READING - 1);
    assign stat.div_last   = step_reg == STEP_W'(ACC_W - 1);
    assign stat.no_valid   = count_reg == '0;
    assign result          = result_reg;

    // control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_offset_reg <= DARK_OFFSET_RESET;
            gain_factor_reg <= GAIN_FACTOR_RESET;
            acc_reg         <= '0;
            count_reg       <= '0;
            pos_reg         <= '0;
            step_reg        <= '0;
        end
        else
        begin
            dark_offset_reg <= dark_offset_next;
            gain_factor_reg <= gain_factor_next;
            acc_reg         <= acc_next;
            count_reg       <= count_next;
            pos_reg         <= pos_next;
            step_reg        <= step_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        diff_reg   <= diff_next;
        adj_reg    <= adj_next;
        result_reg <= result_next;
    end

endmodule

@@ rtl/core/lbem_ctrl.sv @@
module lbem_ctrl
    import lbem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_stall,
    output logic       result_valid,
    input  logic       result_stall,
    input  lbem_stat_t stat,
    output lbem_cmd_t  cmd
);

    lbem_state_t state_reg, state_next;
    logic        result_valid_reg, result_valid_next;
    logic        out_free;

    // output register can take a new beat
    assign out_free = !result_valid_reg || !result_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid && stat.burst_last)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (stat.no_valid)
                begin
                    state_next = ST_EMIT;
                end
                else if (stat.div_last)
                begin
                    state_next = ST_SUBTRACT;
                end
            end
            ST_SUBTRACT: state_next = ST_MULTIPLY;
            ST_MULTIPLY: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd          = '0;
        sample_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                cmd.accept   = sample_valid;
            end
            ST_DIVIDE:   cmd.div_step = !stat.no_valid;
            ST_SUBTRACT: cmd.subtract = 1'b1;
            ST_MULTIPLY: cmd.multiply = 1'b1;
            ST_EMIT:     cmd.emit     = out_free;
            default: ;
        endcase
    end

    // result beat valid
    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        if (cmd.emit)
        begin
            result_valid_next = 1'b1;
        end
    end

    assign result_valid = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

@@ rtl/core/lux_burst_exposure_meter.sv @@
// channel   direction  payload         handshake
// sample    in         lbem_sample_t   sample_valid / sample_stall
// result    out        lbem_result_t   result_valid / result_stall
// cfg       in         cfg_data[15:0]  cfg_write, cfg_index
//
// samples are taken while idle; the last sample of a burst starts the serial divider,
// then the offset, gain and table lookup steps follow in turn
// (an all-saturated burst skips the division, offset and gain and goes straight to the emit step)
// the result sits in an output register; a stalled result holds and only blocks the emit of the next result
// reset clears the burst sum, counts and state and loads the register defaults
module lux_burst_exposure_meter
    import lbem_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  lbem_sample_t         sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output lbem_result_t         result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    lbem_cmd_t  cmd;
    lbem_stat_t stat;

    // sequencer
    lbem_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // sum, divider, gain and lookup
    lbem_datapath #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .sample    (sample),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // no sample taken while the divider runs
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> sample_stall)
        else $error("sample accepted during divide");

    // an all-saturated burst reports zero lux at the slowest index
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.no_valid_samples) |->
            (result.adjusted_lux == '0 && result.shutter_index == NO_VALID_INDEX))
        else $error("bad all-saturated result");

    // a new result beat only comes from the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.emit))
        else $error("result beat without emit");

    // shutter index stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.shutter_index != '0 &&
                          result.shutter_index <= INDEX_W'(THRESH_COUNT + 1)))
        else $error("shutter index out of range");

endmodule
